/* rtl/ashock_pkg.sv */
// Shared types and constants for the acceleration shock detector.
// Used by the interfaces, the axis lanes, the merge stage and the top level.
`default_nettype none
package ashock_pkg;

  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned DIFF_W  = AXIS_W + 1;
  localparam int unsigned SQ_W    = 2 * AXIS_W;
  localparam int unsigned SUM_W   = SQ_W + 2;
  localparam int unsigned THR_W   = 15;
  localparam int unsigned THR_SQ_W = 2 * THR_W;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned MG_SHIFT = 2;

  localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(500);
  localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(500 * 500);

  typedef struct packed {
    logic load1;
    logic load2;
  } ashock_ctl_t;

endpackage
`default_nettype wire

/* rtl/ashock_if.sv */
// Valid/ready channel interfaces for sample and result words.
// Depends on ashock_pkg for field widths.
`default_nettype none
interface ashock_in_if import ashock_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [AXIS_W-1:0] raw_x;
  logic signed [AXIS_W-1:0] raw_y;
  logic signed [AXIS_W-1:0] raw_z;
  logic [WORD_W-1:0]        sample_time_ms;
  logic                     read_failed;

  modport source (output valid, raw_x, raw_y, raw_z, sample_time_ms, read_failed,
                  input ready);
  modport sink   (input valid, raw_x, raw_y, raw_z, sample_time_ms, read_failed,
                  output ready);
endinterface

interface ashock_out_if import ashock_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [AXIS_W-1:0] accel_x_mg;
  logic signed [AXIS_W-1:0] accel_y_mg;
  logic signed [AXIS_W-1:0] accel_z_mg;
  logic                     alert;
  logic [WORD_W-1:0]        sequence_res;
  logic [WORD_W-1:0]        stamp_ms;

  modport source (output valid, accel_x_mg, accel_y_mg, accel_z_mg, alert,
                  sequence_res, stamp_ms, input ready);
  modport sink   (input valid, accel_x_mg, accel_y_mg, accel_z_mg, alert,
                  sequence_res, stamp_ms, output ready);
endinterface
`default_nettype wire

/* rtl/ashock_lane.sv */
// One axis lane: scale to milli-g, difference against the previous sample, square.
// Depends on ashock_pkg; stage loads come from the top level control.
`default_nettype none
module ashock_lane import ashock_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ashock_ctl_t              ctl,
  input  logic signed [AXIS_W-1:0] raw,
  output logic signed [AXIS_W-1:0] mg,
  output logic [SQ_W-1:0]          sq
);

  logic signed [AXIS_W-1:0]   scaled;
  logic signed [AXIS_W-1:0]   prev;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [AXIS_W-1:0]   mg1;
  logic signed [DIFF_W-1:0]   diff1;
  logic signed [2*DIFF_W-1:0] sq_full;

  assign scaled  = raw <<< MG_SHIFT;
  assign diff    = {scaled[AXIS_W-1], scaled} - {prev[AXIS_W-1], prev};
  assign sq_full = diff1 * diff1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (ctl.load1) begin
      prev <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      mg1   <= scaled;
      diff1 <= diff;
    end
    if (ctl.load2) begin
      mg <= mg1;
      sq <= sq_full[SQ_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/ashock_merge.sv */
// Merge stage: sum the lane squares, compare with the squared threshold, hold the result word.
// Depends on ashock_pkg and ashock_out_if.
`default_nettype none
module ashock_merge import ashock_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     v2,
  input  logic                     cmp2,
  input  logic [WORD_W-1:0]        seq2,
  input  logic [WORD_W-1:0]        stamp2,
  input  logic signed [AXIS_W-1:0] mg_x,
  input  logic signed [AXIS_W-1:0] mg_y,
  input  logic signed [AXIS_W-1:0] mg_z,
  input  logic [SQ_W-1:0]          sq_x,
  input  logic [SQ_W-1:0]          sq_y,
  input  logic [SQ_W-1:0]          sq_z,
  input  logic [THR_SQ_W-1:0]      thr_sq,
  output logic                     rdy3,
  ashock_out_if.source             result
);

  logic [SUM_W-1:0] sum;
  logic             over;
  logic             valid;

  assign sum  = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign over = sum > SUM_W'(thr_sq);
  assign rdy3 = !valid || result.ready;
  assign result.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rdy3) begin
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      result.accel_x_mg   <= mg_x;
      result.accel_y_mg   <= mg_y;
      result.accel_z_mg   <= mg_z;
      result.alert        <= cmp2 && over;
      result.sequence_res <= seq2;
      result.stamp_ms     <= stamp2;
    end
  end

endmodule
`default_nettype wire

/* rtl/accel_shock_delta_detector.sv */
// Acceleration shock detector: takes one sample word per clock while sample.ready is high,
// and returns one result word for every sample whose read succeeded. Failed reads are
// accepted and dropped. A sample passes the three lanes' difference and square registers
// and then the merge stage's output register; a threshold write applies to every sample
// accepted at or after the write edge, as the squared threshold is registered from the
// threshold register before such a sample reaches the merge.
`default_nettype none
module accel_shock_delta_detector import ashock_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  ashock_in_if.sink        sample,
  ashock_out_if.source     result
);

  logic [THR_W-1:0]    thr;
  logic [THR_SQ_W-1:0] thr_sq;
  logic                first_pending;
  logic [WORD_W-1:0]   sample_count;
  logic [WORD_W-1:0]   count_next;

  logic                v1, v2;
  logic                cmp1, cmp2;
  logic [WORD_W-1:0]   seq1, seq2;
  logic [WORD_W-1:0]   stamp1, stamp2;
  logic                rdy1, rdy2, rdy3;
  ashock_ctl_t         ctl;

  logic signed [AXIS_W-1:0] mg_x, mg_y, mg_z;
  logic [SQ_W-1:0]          sq_x, sq_y, sq_z;

  assign rdy2         = !v2 || rdy3;
  assign rdy1         = !v1 || rdy2;
  assign sample.ready = rdy1;
  assign ctl.load1    = sample.valid && rdy1 && !sample.read_failed;
  assign ctl.load2    = v1 && rdy2;
  assign count_next   = sample_count + WORD_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
      thr_sq <= THR_SQ_RESET;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      thr_sq <= thr * thr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      sample_count  <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ctl.load1) begin
        first_pending <= 1'b0;
        sample_count  <= count_next;
      end
      if (rdy1) begin
        v1 <= ctl.load1;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      cmp1   <= !first_pending;
      seq1   <= count_next;
      stamp1 <= sample.sample_time_ms;
    end
    if (ctl.load2) begin
      cmp2   <= cmp1;
      seq2   <= seq1;
      stamp2 <= stamp1;
    end
  end

  ashock_lane u_lane_x (
    .clk(clk), .rst(rst), .ctl(ctl), .raw(sample.raw_x), .mg(mg_x), .sq(sq_x)
  );
  ashock_lane u_lane_y (
    .clk(clk), .rst(rst), .ctl(ctl), .raw(sample.raw_y), .mg(mg_y), .sq(sq_y)
  );
  ashock_lane u_lane_z (
    .clk(clk), .rst(rst), .ctl(ctl), .raw(sample.raw_z), .mg(mg_z), .sq(sq_z)
  );

  ashock_merge u_merge (
    .clk(clk), .rst(rst), .v2(v2), .cmp2(cmp2), .seq2(seq2), .stamp2(stamp2),
    .mg_x(mg_x), .mg_y(mg_y), .mg_z(mg_z), .sq_x(sq_x), .sq_y(sq_y), .sq_z(sq_z),
    .thr_sq(thr_sq), .rdy3(rdy3), .result(result)
  );

  a_drop_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready && sample.read_failed) |=>
      ($stable(first_pending) && $stable(sample_count)))
    else $error("failed read changed sample state");

  a_first_no_compare: assert property (@(posedge clk) disable iff (rst)
    (ctl.load1 && first_pending) |=> (!cmp1 && seq1 == sample_count))
    else $error("first sample marked for comparison");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |=> (v1 && $stable(seq1) && $stable(cmp1)))
    else $error("stage one word lost under stall");

endmodule
`default_nettype wire

/* dv/tb_accel_shock_delta_detector.sv */
// Testbench for the acceleration shock detector: drives sample words, predicts each result word
// from its own copy of the scaling, delta energy and sequence count, and checks every field.
// Depends on ashock_pkg, the ashock_in_if/ashock_out_if interfaces and the top level.
`timescale 1ns / 1ps
module tb_accel_shock_delta_detector import ashock_pkg::*; ();

  typedef struct packed {
    logic signed [AXIS_W-1:0] raw_x;
    logic signed [AXIS_W-1:0] raw_y;
    logic signed [AXIS_W-1:0] raw_z;
    logic [WORD_W-1:0]        sample_time_ms;
    logic                     read_failed;
  } sample_word_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] accel_x_mg;
    logic signed [AXIS_W-1:0] accel_y_mg;
    logic signed [AXIS_W-1:0] accel_z_mg;
    logic                     alert;
    logic [WORD_W-1:0]        sequence_res;
    logic [WORD_W-1:0]        stamp_ms;
  } shock_report_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  ashock_in_if  smp_if ();
  ashock_out_if res_if ();

  accel_shock_delta_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (smp_if),
    .result    (res_if)
  );

  always #5 clk = ~clk;

  sample_word_t  sample_queue[$];
  shock_report_t reports_due[$];

  logic [THR_W-1:0]         threshold_mg = THR_RESET;
  logic signed [AXIS_W-1:0] last_x_mg = '0;
  logic signed [AXIS_W-1:0] last_y_mg = '0;
  logic signed [AXIS_W-1:0] last_z_mg = '0;
  logic                     awaiting_first = 1'b1;
  logic [WORD_W-1:0]        stored_count = '0;

  logic signed [AXIS_W-1:0] gen_rx = '0;
  logic signed [AXIS_W-1:0] gen_ry = '0;
  logic signed [AXIS_W-1:0] gen_rz = '0;

  bit          sample_took;
  bit          report_took;
  bit          offering;
  bit          brisk;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_req;
  int unsigned err_count;
  int unsigned reports_checked;

  function automatic int unsigned draw_wait();
    if (brisk) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  task automatic cmp_field(input string name, input logic [WORD_W-1:0] want_v,
                           input logic [WORD_W-1:0] got_v);
    if (got_v !== want_v)
      flag_error($sformatf("result %0d %s: expected %h, got %h",
                           reports_checked, name, want_v, got_v));
  endtask

  task automatic score_sample(input sample_word_t w);
    logic signed [AXIS_W-1:0] mx, my, mz;
    longint                   dx, dy, dz, energy, limit;
    shock_report_t            r;
    if (w.read_failed) return;
    mx = AXIS_W'(w.raw_x <<< MG_SHIFT);
    my = AXIS_W'(w.raw_y <<< MG_SHIFT);
    mz = AXIS_W'(w.raw_z <<< MG_SHIFT);
    dx = longint'(mx) - longint'(last_x_mg);
    dy = longint'(my) - longint'(last_y_mg);
    dz = longint'(mz) - longint'(last_z_mg);
    energy = dx * dx + dy * dy + dz * dz;
    limit = longint'(threshold_mg) * longint'(threshold_mg);
    r.alert = !awaiting_first && (energy > limit);
    awaiting_first = 1'b0;
    last_x_mg = mx;
    last_y_mg = my;
    last_z_mg = mz;
    stored_count = stored_count + 1;
    r.accel_x_mg = mx;
    r.accel_y_mg = my;
    r.accel_z_mg = mz;
    r.sequence_res = stored_count;
    r.stamp_ms = w.sample_time_ms;
    reports_due.push_back(r);
  endtask

  task automatic check_report();
    shock_report_t want;
    reports_checked++;
    if (reports_due.size() == 0) begin
      flag_error($sformatf("result %0d arrived with nothing expected", reports_checked));
      return;
    end
    want = reports_due.pop_front();
    cmp_field("accel_x_mg", want.accel_x_mg, res_if.accel_x_mg);
    cmp_field("accel_y_mg", want.accel_y_mg, res_if.accel_y_mg);
    cmp_field("accel_z_mg", want.accel_z_mg, res_if.accel_z_mg);
    cmp_field("alert", want.alert, res_if.alert);
    cmp_field("sequence_res", want.sequence_res, res_if.sequence_res);
    cmp_field("stamp_ms", want.stamp_ms, res_if.stamp_ms);
  endtask

  // monitor: predict on sample handshake, check on result handshake
  always @(posedge clk) begin
    sample_took = 1'b0;
    report_took = 1'b0;
    if (!rst) begin
      if (smp_if.valid === 1'b1 && smp_if.ready === 1'b1) begin
        sample_took = 1'b1;
        score_sample({smp_if.raw_x, smp_if.raw_y, smp_if.raw_z,
                      smp_if.sample_time_ms, smp_if.read_failed});
      end
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        report_took = 1'b1;
        check_report();
      end
    end
  end

  // driver: offer the next queued word after its gap
  always @(negedge clk) begin
    sample_word_t w;
    if (rst) begin
      offering = 1'b0;
      gap_left = 0;
      smp_if.valid <= 1'b0;
    end else begin
      if (offering && sample_took) begin
        offering = 1'b0;
        gap_left = draw_wait();
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_queue.size() > 0) begin
          w = sample_queue.pop_front();
          offering = 1'b1;
          smp_if.raw_x <= w.raw_x;
          smp_if.raw_y <= w.raw_y;
          smp_if.raw_z <= w.raw_z;
          smp_if.sample_time_ms <= w.sample_time_ms;
          smp_if.read_failed <= w.read_failed;
        end
      end
      smp_if.valid <= offering;
    end
  end

  // receiver: stall per word, or hold off for a long stretch on request
  always @(negedge clk) begin
    if (rst) begin
      stall_left = 0;
      res_if.ready <= 1'b0;
    end else begin
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end else if (report_took) begin
        stall_left = draw_wait();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      res_if.ready <= (stall_left == 0);
    end
  end

  task automatic push_sample(input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                             input logic [AXIS_W-1:0] z, input logic [WORD_W-1:0] t,
                             input logic fail);
    sample_word_t w;
    w.raw_x = x;
    w.raw_y = y;
    w.raw_z = z;
    w.sample_time_ms = t;
    w.read_failed = fail;
    sample_queue.push_back(w);
    if (!fail) begin
      gen_rx = x;
      gen_ry = y;
      gen_rz = z;
    end
  endtask

  task automatic queue_random(input int unsigned n);
    int          dx, dy, dz;
    int unsigned span;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        push_sample(AXIS_W'($urandom()), AXIS_W'($urandom()), AXIS_W'($urandom()),
                    $urandom(), $urandom_range(0, 9) == 0);
      end else begin
        span = (threshold_mg >> 2) + 1;
        dx = int'($urandom_range(0, 2 * span)) - int'(span);
        dy = int'($urandom_range(0, 2 * span)) - int'(span);
        dz = int'($urandom_range(0, 2 * span)) - int'(span);
        push_sample(gen_rx + AXIS_W'(dx), gen_ry + AXIS_W'(dy), gen_rz + AXIS_W'(dz),
                    $urandom(), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (sample_queue.size() != 0 || smp_if.valid || reports_due.size() != 0);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    threshold_mg = v;
    repeat (3) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    smp_if.valid = 1'b0;
    smp_if.raw_x = '0;
    smp_if.raw_y = '0;
    smp_if.raw_z = '0;
    smp_if.sample_time_ms = '0;
    smp_if.read_failed = 1'b0;
    res_if.ready = 1'b0;
    brisk = 1'b0;
    hold_req = 0;
    err_count = 0;
    reports_checked = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // threshold at reset: dropped first read, first sample, exact-boundary energies
    push_sample(16'h7FFF, 16'h8000, 16'h1234, 32'hFFFF_FFFF, 1'b1);
    push_sample(16'h7FFF, 16'h8000, 16'hFFFF, 32'h0000_0000, 1'b0);
    push_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_0001, 1'b0);
    push_sample(16'd125, 16'd0, 16'd0, 32'h0000_0002, 1'b0);
    push_sample(16'd125, 16'd0, 16'd0, 32'h0000_0003, 1'b0);
    push_sample(16'd200, 16'd100, 16'd0, 32'h0000_0004, 1'b0);
    push_sample(16'd200, 16'd100, 16'd1, 32'h0000_0005, 1'b0);
    push_sample(16'hE000, 16'hE000, 16'hE000, 32'h8000_0000, 1'b1);
    push_sample(16'd200, 16'd100, 16'd1, 32'h0000_0006, 1'b0);
    push_sample(16'h1FFF, 16'h1FFF, 16'h1FFF, 32'h7FFF_FFFF, 1'b0);
    push_sample(16'h2000, 16'h2000, 16'h2000, 32'h8000_0000, 1'b0);
    push_sample(16'h1FFF, 16'h1FFF, 16'h1FFF, 32'hFFFF_FFFF, 1'b0);
    push_sample(16'h8000, 16'h8000, 16'h8000, 32'hAAAA_AAAA, 1'b0);
    push_sample(16'h5555, 16'hAAAA, 16'h0F0F, 32'h5555_5555, 1'b0);

    // zero threshold: any change alerts
    write_threshold('0);
    push_sample(16'h5555, 16'hAAAA, 16'h0F0F, 32'h0000_0010, 1'b0);
    push_sample(16'h5555, 16'hAAAA, 16'h0F10, 32'h0000_0011, 1'b0);
    push_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_0012, 1'b1);

    // full-scale threshold
    write_threshold({THR_W{1'b1}});
    push_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_0020, 1'b0);
    push_sample(16'h2000, 16'h0000, 16'h0000, 32'h0000_0021, 1'b0);
    push_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_0022, 1'b0);
    push_sample(16'hE001, 16'h0000, 16'h0000, 32'h0000_0023, 1'b0);
    push_sample(16'h1FFF, 16'h1FFF, 16'h1FFF, 32'h0000_0024, 1'b0);

    write_threshold(THR_W'(1));
    queue_random(240);

    write_threshold({THR_W{1'b1}});
    queue_random(120);
    wait_drained();
    queue_random(120);

    // fill the block while the receiver holds off
    write_threshold(THR_W'($urandom_range(0, 32767)));
    brisk = 1'b1;
    queue_random(240);
    repeat (5) @(posedge clk);
    hold_req = 400;
    wait_drained();
    brisk = 1'b0;

    write_threshold(THR_W'(250));
    queue_random(240);

    write_threshold('0);
    queue_random(240);

    write_threshold(THR_W'(3000));
    queue_random(200);
    wait_drained();
    brisk = 1'b1;
    queue_random(40);

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("accel_shock_delta_detector test passed");
    else
      $display("accel_shock_delta_detector test failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("accel_shock_delta_detector test failed");
    $finish;
  end

endmodule
